FILE: src/bbc_pkg.sv
// shared types, codes and defaults for the block buffer cache slot manager
`timescale 1ns / 1ps

package bbc_pkg;

    // default number of cache slots
    localparam int SLOTS_DEF = 32;

    // fixed field widths
    localparam int TAG_W   = 32;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    // request codes
    localparam logic [1:0] FN_GET    = 2'd0;
    localparam logic [1:0] FN_COMMIT = 2'd1;
    localparam logic [1:0] FN_FLUSH  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNLOADED = 2'd1;
    localparam logic [1:0] ST_PINNED   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic scan_step;
        logic probe_start;
        logic flush_start;
        logic probe_step;
        logic tag_read;
        logic emit_hit;
        logic emit_victim;
        logic emit_full;
        logic emit_commit;
        logic emit_flush_wb;
        logic emit_flush_end;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic tag_hit;
        logic scan_miss;
        logic probe_free;
        logic probe_last;
        logic flush_dirty;
        logic slot_last;
    } t_dp_sts;

endpackage

FILE: src/block_buffer_cache.sv
// top level of the block buffer cache slot manager
`timescale 1ns / 1ps

// Slot manager for a write-back disk block cache with SLOTS slots and
// round-robin replacement. One request is worked on at a time; o_stall is
// high from the transfer of a request until its last result has been
// written into the output register, and a new request is taken while that
// result still waits on i_stall. Block tags sit in a single-port-read RAM,
// so a get walks the tags one per cycle: a hit ends the walk at the
// lowest matching slot; a miss walks every tag, then probes from the
// replacement pointer for an unpinned slot, skipping pinned ones. A commit
// needs no tag lookup. A flush walks every slot once, reads the tag of each
// dirty slot and writes a writeback result for it, then a closing result.
// No clearing pass is needed after reset: a tag is only read behind its
// slot's valid or dirty flag, which reset clears at once.
module block_buffer_cache #(
    parameter int SLOTS = bbc_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [bbc_pkg::TAG_W-1:0]   i_disk_blk,
    input  logic                        i_fetch_on_miss,
    input  logic [bbc_pkg::SLOT_W-1:0]  i_slot_index,
    input  logic                        i_mark_dirty,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bbc_pkg::SLOT_W-1:0]  o_slot,
    output logic                        o_hit,
    output logic                        o_fetch,
    output logic                        o_writeback,
    output logic [bbc_pkg::TAG_W-1:0]   o_writeback_block,
    output logic [1:0]                  o_status,
    output logic [bbc_pkg::COUNT_W-1:0] o_dirty_count,
    output logic                        o_last
);

    bbc_pkg::t_dp_cmd cmd;
    bbc_pkg::t_dp_sts sts;

    // sequencing of lookup, victim probe, commit and flush walk
    bbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // slot flags, tag ram, counters and the result register
    bbc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_disk_blk        (i_disk_blk),
        .i_fetch_on_miss   (i_fetch_on_miss),
        .i_slot_index      (i_slot_index),
        .i_mark_dirty      (i_mark_dirty),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_slot            (o_slot),
        .o_hit             (o_hit),
        .o_fetch           (o_fetch),
        .o_writeback       (o_writeback),
        .o_writeback_block (o_writeback_block),
        .o_status          (o_status),
        .o_dirty_count     (o_dirty_count),
        .o_last            (o_last)
    );

    // a result is only written when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_hit || cmd.emit_victim || cmd.emit_full || cmd.emit_commit
         || cmd.emit_flush_wb || cmd.emit_flush_end) |-> sts.out_free)
        else $error("result written while output register busy");

    // never more than one result per cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.emit_hit, cmd.emit_victim, cmd.emit_full, cmd.emit_commit,
                  cmd.emit_flush_wb, cmd.emit_flush_end}))
        else $error("more than one result in a cycle");

    // a hit result never carries a disk request or an error
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_fetch && !o_writeback && o_status == bbc_pkg::ST_OK))
        else $error("hit result with a disk request or error");

endmodule

FILE: src/bbc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bbc_ctrl.sv
// controller state machine for the block buffer cache
`timescale 1ns / 1ps

module bbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_func,
    input  bbc_pkg::t_dp_sts i_sts,
    output bbc_pkg::t_dp_cmd o_cmd,
    output logic             o_stall
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOOKUP = 10'b0000000010,
        S_HIT    = 10'b0000000100,
        S_PROBE  = 10'b0000001000,
        S_VEMIT  = 10'b0000010000,
        S_FULL   = 10'b0000100000,
        S_COMMIT = 10'b0001000000,
        S_FSCAN  = 10'b0010000000,
        S_FEMIT  = 10'b0100000000,
        S_FEND   = 10'b1000000000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    bbc_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_req = 1'b1;
                    case (i_func)
                        bbc_pkg::FN_GET: begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_LOOKUP;
                        end
                        bbc_pkg::FN_COMMIT: begin
                            n_state = S_COMMIT;
                        end
                        bbc_pkg::FN_FLUSH: begin
                            cmd.flush_start = 1'b1;
                            n_state         = S_FSCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOKUP: begin
                if (i_sts.tag_hit) begin
                    n_state = S_HIT;
                end else if (i_sts.scan_miss) begin
                    cmd.probe_start = 1'b1;
                    n_state         = S_PROBE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_HIT: begin
                if (i_sts.out_free) begin
                    cmd.emit_hit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_PROBE: begin
                if (i_sts.probe_free) begin
                    cmd.tag_read = 1'b1;
                    n_state      = S_VEMIT;
                end else if (i_sts.probe_last) begin
                    n_state = S_FULL;
                end else begin
                    cmd.probe_step = 1'b1;
                end
            end
            S_VEMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit_victim = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FULL: begin
                if (i_sts.out_free) begin
                    cmd.emit_full = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit_commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (i_sts.flush_dirty) begin
                    cmd.tag_read = 1'b1;
                    n_state      = S_FEMIT;
                end else if (i_sts.slot_last) begin
                    n_state = S_FEND;
                end else begin
                    cmd.probe_step = 1'b1;
                end
            end
            S_FEMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit_flush_wb = 1'b1;
                    if (i_sts.slot_last) begin
                        n_state = S_FEND;
                    end else begin
                        cmd.probe_step = 1'b1;
                        n_state        = S_FSCAN;
                    end
                end
            end
            S_FEND: begin
                if (i_sts.out_free) begin
                    cmd.emit_flush_end = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: src/bbc_dp.sv
// datapath: slot flags, tag ram, pointers, dirty count and result register
`timescale 1ns / 1ps

module bbc_dp #(
    parameter int SLOTS = bbc_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbc_pkg::t_dp_cmd            i_cmd,
    output bbc_pkg::t_dp_sts            o_sts,
    input  logic [bbc_pkg::TAG_W-1:0]   i_disk_blk,
    input  logic                        i_fetch_on_miss,
    input  logic [bbc_pkg::SLOT_W-1:0]  i_slot_index,
    input  logic                        i_mark_dirty,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [bbc_pkg::SLOT_W-1:0]  o_slot,
    output logic                        o_hit,
    output logic                        o_fetch,
    output logic                        o_writeback,
    output logic [bbc_pkg::TAG_W-1:0]   o_writeback_block,
    output logic [1:0]                  o_status,
    output logic [bbc_pkg::COUNT_W-1:0] o_dirty_count,
    output logic                        o_last
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    // latched request
    logic [bbc_pkg::TAG_W-1:0]  r_id,    n_id;
    logic                       r_fetch, n_fetch;
    logic [bbc_pkg::SLOT_W-1:0] r_idx,   n_idx;
    logic                       r_mark,  n_mark;

    // slot flags and control
    logic [SLOTS-1:0] r_valid_bits,  n_valid_bits;
    logic [SLOTS-1:0] r_pinned_bits, n_pinned_bits;
    logic [SLOTS-1:0] r_dirty_bits,  n_dirty_bits;
    logic [IW-1:0]    r_ptr,         n_ptr;
    logic [CW-1:0]    r_total,       n_total;
    logic [CW-1:0]    r_scan_cnt,    n_scan_cnt;
    logic             r_cmp_vld,     n_cmp_vld;
    logic [IW-1:0]    r_cmp_idx,     n_cmp_idx;
    logic [IW-1:0]    r_probe,       n_probe;
    logic [IW-1:0]    r_pcnt,        n_pcnt;

    // result register
    logic                        r_out_valid, n_out_valid;
    logic [bbc_pkg::SLOT_W-1:0]  r_o_slot,    n_o_slot;
    logic                        r_o_hit,     n_o_hit;
    logic                        r_o_fetch,   n_o_fetch;
    logic                        r_o_wb,      n_o_wb;
    logic [bbc_pkg::TAG_W-1:0]   r_o_wb_blk,  n_o_wb_blk;
    logic [1:0]                  r_o_status,  n_o_status;
    logic [bbc_pkg::COUNT_W-1:0] r_o_count,   n_o_count;
    logic                        r_o_last,    n_o_last;

    // tag ram
    logic                      ram_we;
    logic                      ram_re;
    logic [IW-1:0]             ram_raddr;
    logic [bbc_pkg::TAG_W-1:0] ram_rdata;

    // helpers
    logic          out_free;
    logic          tag_hit;
    logic [IW-1:0] probe_next;
    logic          victim_wb;
    logic [IW-1:0] commit_ix;
    logic          commit_ok;
    logic          any_emit;

    bbc_ram #(
        .WIDTH (bbc_pkg::TAG_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_probe),
        .i_wdata (r_id),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_stall;
    assign tag_hit    = r_cmp_vld && r_valid_bits[r_cmp_idx] && (ram_rdata == r_id);
    assign probe_next = (r_probe == LAST_SLOT) ? '0 : r_probe + 1'b1;
    assign victim_wb  = r_valid_bits[r_probe] && r_dirty_bits[r_probe];
    assign commit_ix  = IW'(r_idx);
    assign commit_ok  = (int'(r_idx) < SLOTS) && r_valid_bits[commit_ix];
    assign any_emit   = i_cmd.emit_hit || i_cmd.emit_victim || i_cmd.emit_full
                     || i_cmd.emit_commit || i_cmd.emit_flush_wb || i_cmd.emit_flush_end;

    always_comb begin
        n_id          = r_id;
        n_fetch       = r_fetch;
        n_idx         = r_idx;
        n_mark        = r_mark;
        n_valid_bits  = r_valid_bits;
        n_pinned_bits = r_pinned_bits;
        n_dirty_bits  = r_dirty_bits;
        n_ptr         = r_ptr;
        n_total       = r_total;
        n_scan_cnt    = r_scan_cnt;
        n_cmp_vld     = r_cmp_vld;
        n_cmp_idx     = r_cmp_idx;
        n_probe       = r_probe;
        n_pcnt        = r_pcnt;
        n_out_valid   = r_out_valid;
        n_o_slot      = r_o_slot;
        n_o_hit       = r_o_hit;
        n_o_fetch     = r_o_fetch;
        n_o_wb        = r_o_wb;
        n_o_wb_blk    = r_o_wb_blk;
        n_o_status    = r_o_status;
        n_o_count     = r_o_count;
        n_o_last      = r_o_last;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = r_probe;

        if (i_cmd.load_req) begin
            n_id    = i_disk_blk;
            n_fetch = i_fetch_on_miss;
            n_idx   = i_slot_index;
            n_mark  = i_mark_dirty;
        end

        // tag lookup, one read issued per cycle, compared in the cycle after the read
        if (i_cmd.scan_start) begin
            n_scan_cnt = '0;
            n_cmp_vld  = 1'b0;
        end
        if (i_cmd.scan_step) begin
            if (r_scan_cnt != CW'(SLOTS)) begin
                ram_re     = 1'b1;
                ram_raddr  = r_scan_cnt[IW-1:0];
                n_scan_cnt = r_scan_cnt + 1'b1;
                n_cmp_vld  = 1'b1;
                n_cmp_idx  = r_scan_cnt[IW-1:0];
            end else begin
                n_cmp_vld = 1'b0;
            end
        end

        // victim probe and flush walk share the slot cursor
        if (i_cmd.probe_start) begin
            n_probe = r_ptr;
            n_pcnt  = '0;
        end
        if (i_cmd.flush_start) begin
            n_probe = '0;
            n_pcnt  = '0;
        end
        if (i_cmd.probe_step) begin
            n_probe = probe_next;
            n_pcnt  = r_pcnt + 1'b1;
        end
        if (i_cmd.tag_read) begin
            ram_re    = 1'b1;
            ram_raddr = r_probe;
        end

        // result register
        if (!i_stall) begin
            n_out_valid = 1'b0;
        end
        if (any_emit) begin
            n_out_valid = 1'b1;
            n_o_slot    = '0;
            n_o_hit     = 1'b0;
            n_o_fetch   = 1'b0;
            n_o_wb      = 1'b0;
            n_o_wb_blk  = '0;
            n_o_status  = bbc_pkg::ST_OK;
            n_o_last    = 1'b1;
        end

        if (i_cmd.emit_hit) begin
            n_pinned_bits[r_cmp_idx] = 1'b1;
            n_o_slot = bbc_pkg::SLOT_W'(r_cmp_idx);
            n_o_hit  = 1'b1;
        end

        if (i_cmd.emit_victim) begin
            if (victim_wb) begin
                n_o_wb     = 1'b1;
                n_o_wb_blk = ram_rdata;
                if (r_total != '0) begin
                    n_total = r_total - 1'b1;
                end
            end
            if (!r_fetch) begin
                n_total = n_total + 1'b1;
            end
            ram_we                 = 1'b1;
            n_valid_bits[r_probe]  = 1'b1;
            n_pinned_bits[r_probe] = 1'b1;
            n_dirty_bits[r_probe]  = !r_fetch;
            n_ptr                  = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
            n_o_slot               = bbc_pkg::SLOT_W'(r_probe);
            n_o_fetch              = r_fetch;
        end

        if (i_cmd.emit_full) begin
            n_o_status = bbc_pkg::ST_PINNED;
        end

        if (i_cmd.emit_commit) begin
            n_o_slot = r_idx;
            if (commit_ok) begin
                if (r_mark && !r_dirty_bits[commit_ix]) begin
                    n_dirty_bits[commit_ix] = 1'b1;
                    n_total                 = r_total + 1'b1;
                end
                n_pinned_bits[commit_ix] = 1'b0;
            end else begin
                n_o_status = bbc_pkg::ST_UNLOADED;
            end
        end

        if (i_cmd.emit_flush_wb) begin
            n_dirty_bits[r_probe] = 1'b0;
            if (r_total != '0) begin
                n_total = r_total - 1'b1;
            end
            n_o_slot   = bbc_pkg::SLOT_W'(r_probe);
            n_o_wb     = 1'b1;
            n_o_wb_blk = ram_rdata;
            n_o_last   = 1'b0;
        end

        if (any_emit) begin
            n_o_count = bbc_pkg::COUNT_W'(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits  <= '0;
            r_pinned_bits <= '0;
            r_dirty_bits  <= '0;
            r_ptr         <= '0;
            r_total       <= '0;
            r_scan_cnt    <= '0;
            r_cmp_vld     <= 1'b0;
            r_cmp_idx     <= '0;
            r_probe       <= '0;
            r_pcnt        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_valid_bits  <= n_valid_bits;
            r_pinned_bits <= n_pinned_bits;
            r_dirty_bits  <= n_dirty_bits;
            r_ptr         <= n_ptr;
            r_total       <= n_total;
            r_scan_cnt    <= n_scan_cnt;
            r_cmp_vld     <= n_cmp_vld;
            r_cmp_idx     <= n_cmp_idx;
            r_probe       <= n_probe;
            r_pcnt        <= n_pcnt;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_fetch    <= n_fetch;
        r_idx      <= n_idx;
        r_mark     <= n_mark;
        r_o_slot   <= n_o_slot;
        r_o_hit    <= n_o_hit;
        r_o_fetch  <= n_o_fetch;
        r_o_wb     <= n_o_wb;
        r_o_wb_blk <= n_o_wb_blk;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign o_sts.out_free    = out_free;
    assign o_sts.tag_hit     = tag_hit;
    assign o_sts.scan_miss   = r_cmp_vld && (r_cmp_idx == LAST_SLOT) && !tag_hit;
    assign o_sts.probe_free  = !r_pinned_bits[r_probe];
    assign o_sts.probe_last  = (r_pcnt == LAST_SLOT);
    assign o_sts.flush_dirty = r_dirty_bits[r_probe];
    assign o_sts.slot_last   = (r_probe == LAST_SLOT);

    assign o_valid           = r_out_valid;
    assign o_slot            = r_o_slot;
    assign o_hit             = r_o_hit;
    assign o_fetch           = r_o_fetch;
    assign o_writeback       = r_o_wb;
    assign o_writeback_block = r_o_wb_blk;
    assign o_status          = r_o_status;
    assign o_dirty_count     = r_o_count;
    assign o_last            = r_o_last;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the block buffer cache slot manager
`timescale 1ns / 1ps

module tb;

    import bbc_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int CLK_HALF       = 6;
    localparam int ID_POOL        = 40;
    // cycles with no transfer on either channel before the run is abandoned;
    // a miss past a fully pinned ring plus a full flush under heavy stalls
    // stays well below this
    localparam int WATCHDOG_LIMIT = 3000;
    // quiet cycles after the last result, to catch stray results
    localparam int TAIL_CYCLES    = 120;

    typedef struct {
        logic [1:0]         fn;
        logic [TAG_W-1:0]   disk_blk;
        logic               fetch_on_miss;
        logic [SLOT_W-1:0]  slot_index;
        logic               mark_dirty;
    } cache_req_t;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               fetch;
        logic               writeback;
        logic [TAG_W-1:0]   writeback_block;
        logic [1:0]         status;
        logic [COUNT_W-1:0] dirty_count;
        logic               last;
    } cache_rsp_t;

    // slot table mirror plus the queue of results still owed by the block
    class slot_scoreboard;
        bit               slot_valid [SLOTS];
        bit               slot_pinned[SLOTS];
        bit               slot_dirty [SLOTS];
        bit [TAG_W-1:0]   slot_tag   [SLOTS];
        int unsigned      rr_ptr;
        int unsigned      n_dirty;
        cache_rsp_t       owed_q[$];
        int unsigned      errors;
        int unsigned      n_requests, n_results, n_hits, n_misses;
        int unsigned      n_writebacks, n_full, n_unloaded;

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push(int unsigned slot, bit hit, bit fetch, bit wb,
                           bit [TAG_W-1:0] wb_block, logic [1:0] status, bit last);
            cache_rsp_t rsp;
            rsp.slot            = slot[SLOT_W-1:0];
            rsp.hit             = hit;
            rsp.fetch           = fetch;
            rsp.writeback       = wb;
            rsp.writeback_block = wb_block;
            rsp.status          = status;
            rsp.dirty_count     = n_dirty[COUNT_W-1:0];
            rsp.last            = last;
            owed_q.push_back(rsp);
        endfunction

        function int count_pinned();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS; i++) n += slot_pinned[i];
            return n;
        endfunction

        // random pinned slot, or -1 when none is pinned
        function int pick_pinned();
            int cand[$];
            for (int i = 0; i < SLOTS; i++)
                if (slot_pinned[i]) cand.push_back(i);
            if (cand.size() == 0) return -1;
            return cand[$urandom_range(cand.size() - 1)];
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // work out the results of one accepted request and update the mirror
        function void note_request(cache_req_t r);
            int  victim, c, hit_slot;
            bit  found, wb;
            bit [TAG_W-1:0] wb_block;
            n_requests++;
            case (r.fn)
                FN_GET: begin
                    hit_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (slot_valid[i] && slot_tag[i] == r.disk_blk) hit_slot = i;
                    if (hit_slot >= 0) begin
                        slot_pinned[hit_slot] = 1'b1;
                        n_hits++;
                        push(hit_slot, 1'b1, 1'b0, 1'b0, '0, ST_OK, 1'b1);
                    end else begin
                        found  = 1'b0;
                        victim = 0;
                        for (int i = 0; i < SLOTS; i++) begin
                            c = (rr_ptr + i) % SLOTS;
                            if (!found && !slot_pinned[c]) begin
                                victim = c;
                                found  = 1'b1;
                            end
                        end
                        if (!found) begin
                            n_full++;
                            push(0, 1'b0, 1'b0, 1'b0, '0, ST_PINNED, 1'b1);
                        end else begin
                            wb       = slot_valid[victim] && slot_dirty[victim];
                            wb_block = wb ? slot_tag[victim] : '0;
                            if (wb && n_dirty > 0) n_dirty--;
                            slot_valid[victim]  = 1'b1;
                            slot_pinned[victim] = 1'b1;
                            slot_tag[victim]    = r.disk_blk;
                            slot_dirty[victim]  = !r.fetch_on_miss;
                            if (!r.fetch_on_miss) n_dirty++;
                            rr_ptr = (rr_ptr + 1) % SLOTS;
                            n_misses++;
                            n_writebacks += wb;
                            push(victim, 1'b0, r.fetch_on_miss, wb, wb_block, ST_OK, 1'b1);
                        end
                    end
                end
                FN_COMMIT: begin
                    if (r.slot_index >= SLOTS || !slot_valid[r.slot_index]) begin
                        n_unloaded++;
                        push(r.slot_index, 1'b0, 1'b0, 1'b0, '0, ST_UNLOADED, 1'b1);
                    end else begin
                        if (r.mark_dirty && !slot_dirty[r.slot_index]) begin
                            slot_dirty[r.slot_index] = 1'b1;
                            n_dirty++;
                        end
                        slot_pinned[r.slot_index] = 1'b0;
                        push(r.slot_index, 1'b0, 1'b0, 1'b0, '0, ST_OK, 1'b1);
                    end
                end
                FN_FLUSH: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_dirty[i]) begin
                            slot_dirty[i] = 1'b0;
                            if (n_dirty > 0) n_dirty--;
                            n_writebacks++;
                            push(i, 1'b0, 1'b0, 1'b1, slot_tag[i], ST_OK, 1'b0);
                        end
                    end
                    push(0, 1'b0, 1'b0, 1'b0, '0, ST_OK, 1'b1);
                end
                default: ;
            endcase
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                                 n_results, name, got, want));
        endtask

        task check_result(cache_rsp_t got);
            cache_rsp_t want;
            if (owed_q.size() == 0) begin
                report($sformatf("result with none owed: slot %0d status %0d last %0d",
                                 got.slot, got.status, got.last));
            end else begin
                want = owed_q.pop_front();
                check_field("slot",            32'(got.slot),        32'(want.slot));
                check_field("hit",             32'(got.hit),         32'(want.hit));
                check_field("fetch",           32'(got.fetch),       32'(want.fetch));
                check_field("writeback",       32'(got.writeback),   32'(want.writeback));
                check_field("writeback_block", got.writeback_block,  want.writeback_block);
                check_field("status",          32'(got.status),      32'(want.status));
                check_field("dirty_count",     32'(got.dirty_count), 32'(want.dirty_count));
                check_field("last",            32'(got.last),        32'(want.last));
            end
            n_results++;
        endtask
    endclass

    // block ports, with every input at a known value from time zero
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_func          = FN_GET;
    logic [TAG_W-1:0]     i_disk_blk      = '0;
    logic                 i_fetch_on_miss = 1'b0;
    logic [SLOT_W-1:0]    i_slot_index    = '0;
    logic                 i_mark_dirty    = 1'b0;
    logic                 o_valid;
    logic                 i_stall         = 1'b0;
    logic [SLOT_W-1:0]    o_slot;
    logic                 o_hit;
    logic                 o_fetch;
    logic                 o_writeback;
    logic [TAG_W-1:0]     o_writeback_block;
    logic [1:0]           o_status;
    logic [COUNT_W-1:0]   o_dirty_count;
    logic                 o_last;

    slot_scoreboard       sb;
    int unsigned          send_idle_pct = 0;   // sender idle, percent of cycles
    int unsigned          stall_pct     = 0;   // receiver stall, percent of cycles
    int unsigned          stuck_cycles  = 0;
    logic [TAG_W-1:0]     id_pool[ID_POOL];

    block_buffer_cache #(
        .SLOTS (SLOTS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_disk_blk        (i_disk_blk),
        .i_fetch_on_miss   (i_fetch_on_miss),
        .i_slot_index      (i_slot_index),
        .i_mark_dirty      (i_mark_dirty),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_slot            (o_slot),
        .o_hit             (o_hit),
        .o_fetch           (o_fetch),
        .o_writeback       (o_writeback),
        .o_writeback_block (o_writeback_block),
        .o_status          (o_status),
        .o_dirty_count     (o_dirty_count),
        .o_last            (o_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // result side: values seen right after the edge are the ones the edge
    // sampled, since the block and this bench both update with nonblocking writes
    always @(posedge i_clk) begin : result_side
        cache_rsp_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.slot            = o_slot;
            got.hit             = o_hit;
            got.fetch           = o_fetch;
            got.writeback       = o_writeback;
            got.writeback_block = o_writeback_block;
            got.status          = o_status;
            got.dirty_count     = o_dirty_count;
            got.last            = o_last;
            sb.check_result(got);
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: counts cycles without a transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // one request transfer; returns right after the accepting edge with
    // i_valid still high, so back-to-back requests never drop valid
    task automatic send_request(input logic [1:0] fn, input logic [TAG_W-1:0] id,
                                input logic fom, input logic [SLOT_W-1:0] idx,
                                input logic md);
        cache_req_t r;
        r.fn            = fn;
        r.disk_blk      = id;
        r.fetch_on_miss = fom;
        r.slot_index    = idx;
        r.mark_dirty    = md;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= fn;
        i_disk_blk      <= id;
        i_fetch_on_miss <= fom;
        i_slot_index    <= idx;
        i_mark_dirty    <= md;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(r);
    endtask

    // sender holds off until every owed result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // random traffic; with_fill adds a pin-every-slot sequence in the middle
    task automatic run_random(input int n_items, input bit with_fill);
        int          pick, slot;
        logic [TAG_W-1:0] id;
        for (int k = 0; k < n_items; k++) begin
            if (with_fill && k == n_items / 2) begin
                // misses on fresh blocks until the ring is full, then a couple
                // more to hit the all-pinned refusal, then release everything
                while (sb.count_pinned() < SLOTS)
                    send_request(FN_GET, $urandom, 1'($urandom_range(1)),
                                 SLOT_W'($urandom_range(31)), 1'($urandom_range(1)));
                repeat (2)
                    send_request(FN_GET, $urandom, 1'($urandom_range(1)),
                                 SLOT_W'($urandom_range(31)), 1'($urandom_range(1)));
                while (sb.count_pinned() != 0)
                    send_request(FN_COMMIT, $urandom, 1'($urandom_range(1)),
                                 SLOT_W'(sb.pick_pinned()), 1'($urandom_range(1)));
            end
            pick = int'($urandom_range(99));
            if (pick < 48) begin
                // mostly a small block pool so hits and dirty evictions recur
                id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(ID_POOL - 1)];
                send_request(FN_GET, id, 1'($urandom_range(1)), SLOT_W'($urandom_range(31)),
                             1'($urandom_range(1)));
            end else if (pick < 82) begin
                slot = sb.pick_pinned();
                if (slot < 0 || $urandom_range(9) < 3) slot = int'($urandom_range(SLOTS - 1));
                send_request(FN_COMMIT, $urandom, 1'($urandom_range(1)), SLOT_W'(slot),
                             1'($urandom_range(1)));
            end else if (pick < 93) begin
                send_request(FN_FLUSH, $urandom, 1'($urandom_range(1)),
                             SLOT_W'($urandom_range(31)), 1'($urandom_range(1)));
            end else begin
                // unused code, the block must drop it silently
                send_request(2'd3, $urandom, 1'($urandom_range(1)),
                             SLOT_W'($urandom_range(31)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        sb = new();
        id_pool[0] = '0;
        id_pool[1] = '1;
        id_pool[2] = 32'h8000_0000;
        id_pool[3] = 32'h0000_0001;
        for (int i = 4; i < ID_POOL; i++) id_pool[i] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: commits to empty slots, hit and miss, clean and dirty fills,
        // re-dirtying, unpinning an unpinned slot, flushes with and without work
        send_request(FN_COMMIT, '0, 1'b0, 5'd0,  1'b1);
        send_request(FN_COMMIT, '1, 1'b1, 5'd31, 1'b0);
        send_request(FN_GET,    '0, 1'b1, 5'd31, 1'b1);
        send_request(FN_GET,    '0, 1'b0, 5'd0,  1'b0);
        send_request(FN_GET,    '1, 1'b0, 5'd0,  1'b0);
        send_request(FN_GET,    32'h8000_0000, 1'b0, 5'd31, 1'b1);
        send_request(2'd3,      '1, 1'b1, 5'd31, 1'b1);
        send_request(FN_COMMIT, 32'h5555_5555, 1'b0, 5'd0, 1'b1);
        send_request(FN_COMMIT, 32'hAAAA_AAAA, 1'b1, 5'd1, 1'b1);
        send_request(FN_COMMIT, '0, 1'b0, 5'd2, 1'b0);
        send_request(FN_COMMIT, '0, 1'b0, 5'd2, 1'b0);
        send_request(FN_FLUSH,  '1, 1'b1, 5'd31, 1'b1);
        send_request(FN_FLUSH,  '0, 1'b0, 5'd0,  1'b0);
        send_request(FN_GET,    '0, 1'b0, 5'd0,  1'b0);
        send_request(FN_GET,    32'h1234_5678, 1'b0, 5'd10, 1'b0);
        send_request(FN_COMMIT, '0, 1'b0, 5'd3, 1'b1);
        send_request(FN_GET,    '1, 1'b1, 5'd21, 1'b1);
        send_request(FN_COMMIT, '0, 1'b0, 5'd17, 1'b1);
        send_request(FN_FLUSH,  '0, 1'b0, 5'd0,  1'b0);
        wait_drained();

        // random traffic under four idling mixes, drained between them
        run_random(62, 1'b0);
        wait_drained();
        send_idle_pct = 56;
        stall_pct     = 0;
        run_random(62, 1'b1);
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 56;
        run_random(62, 1'b0);
        wait_drained();
        send_idle_pct = 13;
        stall_pct     = 13;
        run_random(62, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d results: %0d hits, %0d misses,",
                 sb.n_requests, sb.n_results, sb.n_hits, sb.n_misses);
        $display("%0d writebacks, %0d all-pinned refusals, %0d commits to unloaded slots",
                 sb.n_writebacks, sb.n_full, sb.n_unloaded);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
src/bbc_pkg.sv
src/bbc_ram.sv
src/bbc_ctrl.sv
src/bbc_dp.sv
src/block_buffer_cache.sv
tb/tb.sv
